// File: hw/rtl/tcgr_pkg.sv
// ----------------------------------------------------------------------------
// tcgr_pkg
// Shared types, codes and the color palette of the text console glyph
// renderer.
// ----------------------------------------------------------------------------
package tcgr_pkg;

  // Glyph cell width is fixed at eight pixels, one byte per glyph row
  localparam int GLYPH_WIDTH = 8;
  localparam int X_SHIFT     = $clog2(GLYPH_WIDTH);

  // Operation codes
  localparam logic [1:0] OP_PUT_CHAR   = 2'd0;
  localparam logic [1:0] OP_SET_CURSOR = 2'd1;
  localparam logic [1:0] OP_LOAD_FONT  = 2'd2;

  // Control characters
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_TAB       = 8'd9;
  localparam logic [7:0] CH_NEWLINE   = 8'd10;

  // Tab stop distance in columns
  localparam logic [8:0] TAB_STEP = 9'd4;

  // Register indexes (word address bits)
  localparam logic [2:0] REG_TEXT_COLUMNS = 3'd0;
  localparam logic [2:0] REG_TEXT_ROWS    = 3'd1;
  localparam logic [2:0] REG_FG_INDEX     = 3'd2;
  localparam logic [2:0] REG_BG_INDEX     = 3'd3;
  localparam logic [2:0] REG_FG_INTENSE   = 3'd4;
  localparam logic [2:0] REG_BG_INTENSE   = 3'd5;

  // Register reset values
  localparam logic [7:0] TEXT_COLUMNS_RST = 8'd80;
  localparam logic [6:0] TEXT_ROWS_RST    = 7'd30;
  localparam logic [2:0] FG_INDEX_RST     = 3'd7;
  localparam logic [2:0] BG_INDEX_RST     = 3'd0;

  // 2x8 palette: normal row, then bright row
  localparam logic [31:0] PALETTE [2][8] = '{
    '{32'hff000000, 32'hffa00000, 32'hff0aac00, 32'hffaaa700,
      32'hfa0001aa, 32'hffa001aa, 32'hff0aaaaa, 32'hffaaaaaa},
    '{32'hff000000, 32'hfff00000, 32'hff0ffc00, 32'hfffffc00,
      32'hff0003ff, 32'hfff003ff, 32'hff0fffff, 32'hffffffff}
  };

  // Draw request from the cursor unit to the row sequencer
  typedef struct packed {
    logic       start;
    logic [7:0] col;
    logic [6:0] row;
    logic [7:0] code;
  } draw_req_t;

  // Character code folded into the glyph range; count is at least half of 256
  function automatic logic [7:0] glyph_wrap(logic [7:0] code, int count);
    logic [8:0] wide;
    logic [8:0] lim;
    wide = {1'b0, code};
    lim  = 9'(count);
    if (wide >= lim) begin
      wide = wide - lim;
    end
    return wide[7:0];
  endfunction

endpackage

// File: hw/rtl/text_console_glyph_renderer_core.sv
// ----------------------------------------------------------------------------
// text_console_glyph_renderer_core
// Text console: cursor handling, font store and glyph row output.
// ----------------------------------------------------------------------------
// A put-character item that draws a glyph (any code but newline and tab)
// holds in_ready_o low after its accept until the row sequencer has issued
// every glyph row; a stalled sink stretches the hold, as a row is only
// read once the read stage and the output register have room. Such an item
// gives GLYPH_HEIGHT result beats, one per cycle while the sink is ready.
// The hold is set by the font store's single read port, which the row
// sequencer steps through one glyph row per cycle while the read stage has
// room. Newline, tab, set cursor, font row loads and the unused operation
// give no beats. Colors on fg_argb_o/bg_argb_o follow the palette
// registers. Registers are written and read over the APB-style port
// at byte address 4*index.
module text_console_glyph_renderer_core #(
  parameter int GLYPH_HEIGHT = 16,
  parameter int GLYPH_COUNT  = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // operation channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [7:0]  char_code_i,
  input  logic [3:0]  glyph_row_i,
  input  logic [7:0]  font_bits_i,
  input  logic [7:0]  new_column_i,
  input  logic [6:0]  new_row_i,
  // glyph row channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [10:0] pixel_x_o,
  output logic [10:0] pixel_y_o,
  output logic [7:0]  row_bits_o,
  output logic [31:0] fg_argb_o,
  output logic [31:0] bg_argb_o,
  output logic        last_row_o
);
  import tcgr_pkg::*;

  localparam int FontDepth = GLYPH_COUNT * GLYPH_HEIGHT;
  localparam int AddrW     = $clog2(FontDepth);

  logic [7:0]       text_columns_q;
  logic [6:0]       text_rows_q;
  logic [2:0]       fg_index_q, bg_index_q;
  logic             fg_intense_q, bg_intense_q;
  logic             cfg_wr;
  logic             in_accept;
  logic             busy;
  logic             font_we;
  logic [AddrW-1:0] font_waddr;
  logic             rd_en;
  logic [AddrW-1:0] rd_addr;
  logic [7:0]       rd_data;
  draw_req_t        draw;

  // configuration registers
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_columns_q <= TEXT_COLUMNS_RST;
      text_rows_q    <= TEXT_ROWS_RST;
      fg_index_q     <= FG_INDEX_RST;
      bg_index_q     <= BG_INDEX_RST;
      fg_intense_q   <= 1'b0;
      bg_intense_q   <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_TEXT_COLUMNS: text_columns_q <= pwdata[7:0];
        REG_TEXT_ROWS:    text_rows_q    <= pwdata[6:0];
        REG_FG_INDEX:     fg_index_q     <= pwdata[2:0];
        REG_BG_INDEX:     bg_index_q     <= pwdata[2:0];
        REG_FG_INTENSE:   fg_intense_q   <= pwdata[0];
        REG_BG_INTENSE:   bg_intense_q   <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  // register readback
  always_comb begin
    case (paddr[4:2])
      REG_TEXT_COLUMNS: prdata = 32'(text_columns_q);
      REG_TEXT_ROWS:    prdata = 32'(text_rows_q);
      REG_FG_INDEX:     prdata = 32'(fg_index_q);
      REG_BG_INDEX:     prdata = 32'(bg_index_q);
      REG_FG_INTENSE:   prdata = 32'(fg_intense_q);
      REG_BG_INTENSE:   prdata = 32'(bg_intense_q);
      default:          prdata = 32'd0;
    endcase
  end

  // input handshake
  assign in_ready_o = !busy;
  assign in_accept  = in_valid_i && in_ready_o;

  // font row load
  assign font_we = in_accept && (operation_i == OP_LOAD_FONT)
                   && (int'(glyph_row_i) < GLYPH_HEIGHT);
  assign font_waddr = AddrW'(glyph_wrap(char_code_i, GLYPH_COUNT)) * AddrW'(GLYPH_HEIGHT)
                      + AddrW'(glyph_row_i);

  tcgr_cursor u_cursor (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (in_accept),
    .operation_i    (operation_i),
    .char_code_i    (char_code_i),
    .new_column_i   (new_column_i),
    .new_row_i      (new_row_i),
    .text_columns_i (text_columns_q),
    .text_rows_i    (text_rows_q),
    .draw_o         (draw)
  );

  tcgr_font_mem #(
    .Depth (FontDepth),
    .AddrW (AddrW)
  ) u_font_mem (
    .clk_i   (clk_i),
    .we_i    (font_we),
    .waddr_i (font_waddr),
    .wdata_i (font_bits_i),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  tcgr_seq #(
    .GlyphHeight (GLYPH_HEIGHT),
    .GlyphCount  (GLYPH_COUNT),
    .AddrW       (AddrW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .draw_i      (draw),
    .busy_o      (busy),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .pixel_x_o   (pixel_x_o),
    .pixel_y_o   (pixel_y_o),
    .row_bits_o  (row_bits_o),
    .last_row_o  (last_row_o)
  );

  // colors from the palette
  assign fg_argb_o = PALETTE[fg_intense_q][fg_index_q];
  assign bg_argb_o = PALETTE[bg_intense_q][bg_index_q];

endmodule

// File: hw/rtl/tcgr_font_mem.sv
// ----------------------------------------------------------------------------
// tcgr_font_mem
// Font store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tcgr_font_mem #(
  parameter int Depth = 4096,
  parameter int AddrW = 12
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [7:0]       wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem [Depth];
  logic [7:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/tcgr_cursor.sv
// ----------------------------------------------------------------------------
// tcgr_cursor
// Cursor column/row state and its update per console operation; issues a
// draw request for every character that produces a glyph.
// ----------------------------------------------------------------------------
module tcgr_cursor (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [1:0]          operation_i,
  input  logic [7:0]          char_code_i,
  input  logic [7:0]          new_column_i,
  input  logic [6:0]          new_row_i,
  input  logic [7:0]          text_columns_i,
  input  logic [6:0]          text_rows_i,
  output tcgr_pkg::draw_req_t draw_o
);
  import tcgr_pkg::*;

  logic [7:0] col_q, col_d;
  logic [6:0] row_q, row_d;
  logic [7:0] last_col;
  logic [6:0] last_row;
  logic [6:0] row_adv;
  logic [8:0] col_p1;
  logic [8:0] col_p4;
  draw_req_t  draw;

  // last valid position, zero counts act as one
  assign last_col = (text_columns_i == 8'd0) ? 8'd0 : text_columns_i - 8'd1;
  assign last_row = (text_rows_i == 7'd0) ? 7'd0 : text_rows_i - 7'd1;

  // row advance saturates: no scrolling
  assign row_adv = (row_q >= last_row) ? last_row : row_q + 7'd1;
  assign col_p1  = {1'b0, col_q} + 9'd1;
  assign col_p4  = {1'b0, col_q} + TAB_STEP;

  // next cursor and draw request
  always_comb begin
    col_d      = col_q;
    row_d      = row_q;
    draw.start = 1'b0;
    draw.col   = col_q;
    draw.row   = row_q;
    draw.code  = char_code_i;
    case (operation_i)
      OP_PUT_CHAR: begin
        case (char_code_i)
          CH_NEWLINE: begin
            col_d = 8'd0;
            row_d = row_adv;
          end
          CH_TAB: begin
            if (col_p4 > {1'b0, last_col}) begin
              col_d = 8'd0;
              row_d = row_adv;
            end else begin
              col_d = col_p4[7:0];
            end
          end
          CH_BACKSPACE: begin
            if (col_q != 8'd0) begin
              col_d = col_q - 8'd1;
            end
            draw.start = 1'b1;
            draw.col   = col_d;
            draw.code  = 8'd0;
          end
          default: begin
            draw.start = 1'b1;
            if (col_p1 > {1'b0, last_col}) begin
              col_d = 8'd0;
              row_d = row_adv;
            end else begin
              col_d = col_p1[7:0];
            end
          end
        endcase
      end
      OP_SET_CURSOR: begin
        col_d = (new_column_i > last_col) ? last_col : new_column_i;
        row_d = (new_row_i > last_row) ? last_row : new_row_i;
      end
      default: begin
      end
    endcase
    draw.start = draw.start & accept_i;
  end

  // cursor registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= 8'd0;
      row_q <= 7'd0;
    end else if (accept_i) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign draw_o = draw;

endmodule

// File: hw/rtl/tcgr_seq.sv
// ----------------------------------------------------------------------------
// tcgr_seq
// Row sequencer: steps one glyph row per cycle, while the read stage has
// room, through the font store read port, then through a read stage and an
// output register toward the result channel.
// ----------------------------------------------------------------------------
module tcgr_seq #(
  parameter int GlyphHeight = 16,
  parameter int GlyphCount  = 256,
  parameter int AddrW       = 12
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tcgr_pkg::draw_req_t draw_i,
  output logic                busy_o,
  output logic                rd_en_o,
  output logic [AddrW-1:0]    rd_addr_o,
  input  logic [7:0]          rd_data_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [10:0]         pixel_x_o,
  output logic [10:0]         pixel_y_o,
  output logic [7:0]          row_bits_o,
  output logic                last_row_o
);
  import tcgr_pkg::*;

  localparam int RowW = $clog2(GlyphHeight);
  localparam logic [RowW-1:0] RowLast = RowW'(GlyphHeight - 1);

  logic             active_q;
  logic [RowW-1:0]  rcnt_q;
  logic [AddrW-1:0] addr_q;
  logic [10:0]      y_q;
  logic [10:0]      x_q;
  logic             s1_valid_q;
  logic [10:0]      s1_x_q, s1_y_q;
  logic             s1_last_q;
  logic             out_valid_q;
  logic [10:0]      out_x_q, out_y_q;
  logic [7:0]       out_bits_q;
  logic             out_last_q;
  logic             issue;
  logic             s1_move;
  logic             row_is_last;
  logic [11:0]      y_start;
  logic [AddrW-1:0] base_addr;

  // start position of a glyph
  assign y_start   = 12'(draw_i.row) * 12'(GlyphHeight);
  assign base_addr = AddrW'(glyph_wrap(draw_i.code, GlyphCount)) * AddrW'(GlyphHeight);

  // pipeline advance
  assign s1_move     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign issue       = active_q && (!s1_valid_q || s1_move);
  assign row_is_last = (rcnt_q == RowLast);

  // row counter, address and y step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      rcnt_q   <= '0;
    end else if (draw_i.start) begin
      active_q <= 1'b1;
      rcnt_q   <= '0;
    end else if (issue) begin
      rcnt_q <= rcnt_q + RowW'(1);
      if (row_is_last) begin
        active_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (draw_i.start) begin
      addr_q <= base_addr;
      y_q    <= y_start[10:0];
      x_q    <= 11'(draw_i.col) << X_SHIFT;
    end else if (issue) begin
      addr_q <= addr_q + AddrW'(1);
      y_q    <= y_q + 11'd1;
    end
  end

  // read stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (issue) begin
      s1_valid_q <= 1'b1;
    end else if (s1_move) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_x_q    <= x_q;
      s1_y_q    <= y_q;
      s1_last_q <= row_is_last;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_move) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_x_q    <= s1_x_q;
      out_y_q    <= s1_y_q;
      out_bits_q <= rd_data_i;
      out_last_q <= s1_last_q;
    end
  end

  assign busy_o      = active_q;
  assign rd_en_o     = issue;
  assign rd_addr_o   = addr_q;
  assign out_valid_o = out_valid_q;
  assign pixel_x_o   = out_x_q;
  assign pixel_y_o   = out_y_q;
  assign row_bits_o  = out_bits_q;
  assign last_row_o  = out_last_q;

endmodule

// File: hw/rtl/tcgr_checker.sv
// ----------------------------------------------------------------------------
// tcgr_checker
// Port-level checks of the glyph renderer, bound to the top level.
// ----------------------------------------------------------------------------
module tcgr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        pready,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [1:0]  operation_i,
  input logic [7:0]  char_code_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [10:0] pixel_x_o,
  input logic [10:0] pixel_y_o,
  input logic        last_row_o
);
  import tcgr_pkg::*;

  // APB completes every access in its first access cycle
  a_pready_high: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

  // a stalled result beat holds its position
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pixel_y_o) && $stable(pixel_x_o))
    else $error("stalled result beat changed");

  // rows of one glyph follow back to back, one pixel line apart
  a_next_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_row_o |=>
      out_valid_o && (pixel_y_o == 11'($past(pixel_y_o) + 11'd1))
      && (pixel_x_o == $past(pixel_x_o)))
    else $error("glyph row sequence broken");

  // a drawing character makes the block busy in the next cycle
  a_draw_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (operation_i == OP_PUT_CHAR)
      && (char_code_i != CH_TAB) && (char_code_i != CH_NEWLINE) |=> !in_ready_o)
    else $error("drawing character did not start a glyph");

endmodule

bind text_console_glyph_renderer_core tcgr_checker u_tcgr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .pready      (pready),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .operation_i (operation_i),
  .char_code_i (char_code_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .pixel_x_o   (pixel_x_o),
  .pixel_y_o   (pixel_y_o),
  .last_row_o  (last_row_o)
);
